// ===== hw/rtl/zps_pkg.sv =====
// Package for the encoder zero-set / zero-reset power-cycle sequencer.
// Holds the sequencer step type, register indexes and counter constants.
// No dependencies.
`default_nettype none

package zps_pkg;

	// Width of the tick counter, and of the timing registers
	localparam int COUNT_WIDTH = 16;
	localparam int TICK_WIDTH  = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;

	// Configuration port
	localparam int CFG_IDX_WIDTH = 2;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_OFF_TICKS  = 2'd0,
		REG_ON_TICKS   = 2'd1,
		REG_DONE_TICKS = 2'd2
	} cfg_reg_t;

	localparam logic [TICK_WIDTH-1:0] OFF_TICKS_RST  = TICK_WIDTH'(200);
	localparam logic [TICK_WIDTH-1:0] ON_TICKS_RST   = TICK_WIDTH'(500);
	localparam logic [TICK_WIDTH-1:0] DONE_TICKS_RST = TICK_WIDTH'(100);

	// Sequencer phases
	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_START     = 3'd1,
		ST_OFF_WAIT  = 3'd2,
		ST_ON_HOLD   = 3'd3,
		ST_DONE_HOLD = 3'd4
	} step_t;

endpackage : zps_pkg

`default_nettype wire

// ===== hw/rtl/zps_cmd_if.sv =====
// Command channel: one tick with host command bits per beat.
// valid/ready handshake; no dependencies.
`default_nettype none

interface zps_cmd_if;
	logic valid;
	logic ready;
	logic set_trigger;
	logic reset_trigger;
	logic manual_enable;
	logic force_set;
	logic force_reset;
	logic force_power;

	modport source (
		output valid, set_trigger, reset_trigger, manual_enable,
		output force_set, force_reset, force_power,
		input  ready
	);
	modport sink (
		input  valid, set_trigger, reset_trigger, manual_enable,
		input  force_set, force_reset, force_power,
		output ready
	);
endinterface : zps_cmd_if

`default_nettype wire

// ===== hw/rtl/zps_status_if.sv =====
// Status channel: pin levels, flags and phase LEDs after each tick, one per beat.
// valid/ready handshake; no dependencies.
`default_nettype none

interface zps_status_if;
	logic valid;
	logic ready;
	logic zero_set_pin;
	logic zero_reset_pin;
	logic power_pin;
	logic busy_flag;
	logic done_flag;
	logic manual_status;
	logic led_phase_one;
	logic led_phase_two;
	logic led_phase_three;

	modport source (
		output valid, zero_set_pin, zero_reset_pin, power_pin,
		output busy_flag, done_flag, manual_status,
		output led_phase_one, led_phase_two, led_phase_three,
		input  ready
	);
	modport sink (
		input  valid, zero_set_pin, zero_reset_pin, power_pin,
		input  busy_flag, done_flag, manual_status,
		input  led_phase_one, led_phase_two, led_phase_three,
		output ready
	);
endinterface : zps_status_if

`default_nettype wire

// ===== hw/rtl/encoder_zero_power_cycle_sequencer.sv =====
// Encoder zero-set / zero-reset power-cycle sequencer, top level.
// Depends on zps_pkg, zps_cmd_if and zps_status_if.
//
// Usage:
//  - cmd carries one tick per beat: set/reset triggers, manual enable and the
//    three manual pin levels. status returns exactly one beat per tick with
//    the pin levels, busy/done/manual flags and phase LEDs after that tick.
//  - cfg_we/cfg_index/cfg_data write off_ticks (0), on_ticks (1) and
//    done_ticks (2); other indexes are ignored. Write only while idle.
//  - An accepted tick is registered in the input register; its status beat is
//    presented from the result register once that register has room.
//  - Throughput: one tick per cycle unless status stalls. The sequencer state, the
//    saturating tick counter and its single compare against the selected
//    register all update in the cycle the tick leaves the input register.
//  - When status stalls, the result register holds and the input register
//    still takes one more tick; cmd.ready then drops until status drains.
//  - Reset (arst_n low) clears both registers' valid bits, returns to idle
//    with pins set 0 / reset 0 / power 1, flags and LEDs off, and loads the
//    register defaults 200, 500 and 100.
`default_nettype none

module encoder_zero_power_cycle_sequencer
	import zps_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [TICK_WIDTH-1:0]    cfg_data,
	zps_cmd_if.sink                       cmd,
	zps_status_if.source                  status
);

	// Configuration registers
	logic [TICK_WIDTH-1:0] off_ticks_q, on_ticks_q, done_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_ticks_q  <= OFF_TICKS_RST;
			on_ticks_q   <= ON_TICKS_RST;
			done_ticks_q <= DONE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFF_TICKS:  off_ticks_q  <= cfg_data;
				REG_ON_TICKS:   on_ticks_q   <= cfg_data;
				REG_DONE_TICKS: done_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: input register s1, result register s2
	logic valid_s1, valid_s2;
	logic adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || status.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	logic set_trig_s1, rst_trig_s1, manual_s1, f_set_s1, f_rst_s1, f_pwr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			set_trig_s1 <= cmd.set_trigger;
			rst_trig_s1 <= cmd.reset_trigger;
			manual_s1   <= cmd.manual_enable;
			f_set_s1    <= cmd.force_set;
			f_rst_s1    <= cmd.force_reset;
			f_pwr_s1    <= cmd.force_power;
		end
	end

	// Sequencer state
	step_t                  step_q, step_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic                   set_chosen_q, set_chosen_d;
	logic                   pin_set_q, pin_rst_q, pin_pwr_q;
	logic                   pin_set_d, pin_rst_d, pin_pwr_d;
	logic                   busy_q, done_q, manual_q;
	logic                   busy_d, done_d, manual_d;
	logic                   led1_q, led2_q, led3_q;
	logic                   led1_d, led2_d, led3_d;

	// Commands only count while idle
	logic is_idle, trig_set, trig_rst, man_en;

	assign is_idle  = (step_q == ST_IDLE);
	assign trig_set = set_trig_s1 && is_idle;
	assign trig_rst = rst_trig_s1 && is_idle;
	assign man_en   = manual_s1 && is_idle;

	// Saturating counter increment and phase-end compare
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [TICK_WIDTH-1:0]  limit;
	logic                   reached;

	always_comb begin
		cnt_inc = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
		case (step_q)
			ST_OFF_WAIT: limit = off_ticks_q;
			ST_ON_HOLD:  limit = on_ticks_q;
			default:     limit = done_ticks_q;
		endcase
		reached = (CMP_WIDTH'(cnt_inc) >= CMP_WIDTH'(limit));
	end

	// Next step
	always_comb begin
		step_d = step_q;
		unique case (step_q)
			ST_IDLE:      if (!man_en && (trig_set || trig_rst)) step_d = ST_START;
			ST_START:     step_d = ST_OFF_WAIT;
			ST_OFF_WAIT:  if (reached) step_d = ST_ON_HOLD;
			ST_ON_HOLD:   if (reached) step_d = ST_DONE_HOLD;
			ST_DONE_HOLD: if (reached) step_d = ST_IDLE;
			default:      step_d = ST_IDLE;
		endcase
	end

	// Pins, flags, LEDs and counter for this tick
	always_comb begin
		cnt_d        = cnt_q;
		set_chosen_d = set_chosen_q;
		pin_set_d    = pin_set_q;
		pin_rst_d    = pin_rst_q;
		pin_pwr_d    = pin_pwr_q;
		busy_d       = busy_q;
		done_d       = done_q;
		manual_d     = 1'b0;
		led1_d       = led1_q;
		led2_d       = led2_q;
		led3_d       = led3_q;

		// manual pin control, idle only
		if (is_idle) begin
			manual_d  = man_en;
			pin_set_d = man_en ? f_set_s1 : 1'b0;
			pin_rst_d = man_en ? f_rst_s1 : 1'b0;
			pin_pwr_d = man_en ? f_pwr_s1 : 1'b1;
		end

		unique case (step_q)
			ST_IDLE: begin
				if (!man_en && (trig_set || trig_rst)) begin
					set_chosen_d = trig_set;
					busy_d       = 1'b1;
					done_d       = 1'b0;
				end
			end
			ST_START: begin
				pin_pwr_d = 1'b0;
				pin_set_d = set_chosen_q;
				pin_rst_d = !set_chosen_q;
				cnt_d     = '0;
			end
			ST_OFF_WAIT: begin
				led1_d = 1'b1;
				cnt_d  = cnt_inc;
				if (reached) begin
					pin_pwr_d = 1'b1;
					cnt_d     = '0;
				end
			end
			ST_ON_HOLD: begin
				led1_d = 1'b0;
				led2_d = 1'b1;
				cnt_d  = cnt_inc;
				if (reached) begin
					pin_set_d = 1'b0;
					pin_rst_d = 1'b0;
					busy_d    = 1'b0;
					done_d    = 1'b1;
					cnt_d     = '0;
				end
			end
			ST_DONE_HOLD: begin
				led2_d = 1'b0;
				led3_d = 1'b1;
				cnt_d  = cnt_inc;
				if (reached) begin
					done_d = 1'b0;
					led1_d = 1'b0;
					led2_d = 1'b0;
					led3_d = 1'b0;
				end
			end
			default: begin
				led1_d = 1'b0;
				led2_d = 1'b0;
				led3_d = 1'b0;
			end
		endcase
	end

	// State update once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_IDLE;
			cnt_q        <= '0;
			set_chosen_q <= 1'b0;
			pin_set_q    <= 1'b0;
			pin_rst_q    <= 1'b0;
			pin_pwr_q    <= 1'b1;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			manual_q     <= 1'b0;
			led1_q       <= 1'b0;
			led2_q       <= 1'b0;
			led3_q       <= 1'b0;
		end else if (adv_s1) begin
			step_q       <= step_d;
			cnt_q        <= cnt_d;
			set_chosen_q <= set_chosen_d;
			pin_set_q    <= pin_set_d;
			pin_rst_q    <= pin_rst_d;
			pin_pwr_q    <= pin_pwr_d;
			busy_q       <= busy_d;
			done_q       <= done_d;
			manual_q     <= manual_d;
			led1_q       <= led1_d;
			led2_q       <= led2_d;
			led3_q       <= led3_d;
		end
	end

	// Result register
	logic set_s2, rst_s2, pwr_s2, busy_s2, done_s2, manual_s2, led1_s2, led2_s2, led3_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || status.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			set_s2    <= pin_set_d;
			rst_s2    <= pin_rst_d;
			pwr_s2    <= pin_pwr_d;
			busy_s2   <= busy_d;
			done_s2   <= done_d;
			manual_s2 <= manual_d;
			led1_s2   <= led1_d;
			led2_s2   <= led2_d;
			led3_s2   <= led3_d;
		end
	end

	assign status.valid           = valid_s2;
	assign status.zero_set_pin    = set_s2;
	assign status.zero_reset_pin  = rst_s2;
	assign status.power_pin       = pwr_s2;
	assign status.busy_flag       = busy_s2;
	assign status.done_flag       = done_s2;
	assign status.manual_status   = manual_s2;
	assign status.led_phase_one   = led1_s2;
	assign status.led_phase_two   = led2_s2;
	assign status.led_phase_three = led3_s2;

	// Checks
	a_busy_not_manual: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !manual_q)
		else $error("manual status set during sequence");

	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("busy and done both set");

	a_off_wait_power: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_OFF_WAIT) |-> (!pin_pwr_q && (pin_set_q != pin_rst_q)))
		else $error("power or zero lines wrong in off wait");

	a_led_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({led1_q, led2_q, led3_q}))
		else $error("more than one phase LED on");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("tick advanced without a result beat");

endmodule : encoder_zero_power_cycle_sequencer

`default_nettype wire

// ===== dv/tb_encoder_zero_power_cycle_sequencer.sv =====
// Testbench for the encoder zero-set / zero-reset power-cycle sequencer.
// Drives command ticks and timing register writes, and checks every status beat
// against an in-bench model. Depends on zps_pkg, zps_cmd_if, zps_status_if and the RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_encoder_zero_power_cycle_sequencer;
	import zps_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// One command tick, fields in channel order
	typedef struct packed {
		logic set_trigger;
		logic reset_trigger;
		logic manual_enable;
		logic force_set;
		logic force_reset;
		logic force_power;
	} tick_t;

	// Pin levels, flags and LEDs after one tick
	typedef struct packed {
		logic zero_set_pin;
		logic zero_reset_pin;
		logic power_pin;
		logic busy_flag;
		logic done_flag;
		logic manual_status;
		logic led_phase_one;
		logic led_phase_two;
		logic led_phase_three;
	} pins_t;

	// Tracks the sequencer from accepted ticks and holds the status beats still owed
	class sequencer_tracker;
		step_t                 phase;
		logic [COUNT_WIDTH-1:0] ticks;
		logic [TICK_WIDTH-1:0]  off_lim, on_lim, done_lim;
		logic                   set_sel;
		pins_t                  now;
		pins_t                  owed_q[$];
		int                     errors;
		string                  field_name[9];

		function new();
			phase    = ST_IDLE;
			ticks    = '0;
			off_lim  = OFF_TICKS_RST;
			on_lim   = ON_TICKS_RST;
			done_lim = DONE_TICKS_RST;
			set_sel  = 1'b0;
			now      = '0;
			now.power_pin = 1'b1;
			errors   = 0;
			field_name = '{"zero_set_pin", "zero_reset_pin", "power_pin", "busy_flag",
				"done_flag", "manual_status", "led_phase_one", "led_phase_two",
				"led_phase_three"};
		endfunction

		function void set_limit(cfg_reg_t idx, logic [TICK_WIDTH-1:0] v);
			case (idx)
				REG_OFF_TICKS:  off_lim = v;
				REG_ON_TICKS:   on_lim = v;
				REG_DONE_TICKS: done_lim = v;
				default: ;
			endcase
		endfunction

		// saturating count, then compare; a limit of zero acts as one
		function bit count_hits(logic [TICK_WIDTH-1:0] lim);
			if (ticks != COUNT_MAX)
				ticks = ticks + 1'b1;
			return ticks >= lim;
		endfunction

		function void accept_tick(tick_t t);
			logic go_set, go_rst, man;
			go_set = t.set_trigger;
			go_rst = t.reset_trigger;
			man    = t.manual_enable;
			// commands only count while idle
			if (phase != ST_IDLE) begin
				go_set = 1'b0;
				go_rst = 1'b0;
				man    = 1'b0;
			end
			if (phase == ST_IDLE) begin
				now.manual_status = man;
				if (man) begin
					now.zero_set_pin   = t.force_set;
					now.zero_reset_pin = t.force_reset;
					now.power_pin      = t.force_power;
				end else begin
					now.zero_set_pin   = 1'b0;
					now.zero_reset_pin = 1'b0;
					now.power_pin      = 1'b1;
				end
			end else begin
				now.manual_status = 1'b0;
			end
			case (phase)
				ST_IDLE: begin
					if (!man && (go_set || go_rst)) begin
						set_sel = go_set;
						phase   = ST_START;
						now.busy_flag = 1'b1;
						now.done_flag = 1'b0;
					end
				end
				ST_START: begin
					now.power_pin      = 1'b0;
					now.zero_set_pin   = set_sel;
					now.zero_reset_pin = !set_sel;
					ticks = '0;
					phase = ST_OFF_WAIT;
				end
				ST_OFF_WAIT: begin
					now.led_phase_one = 1'b1;
					if (count_hits(off_lim)) begin
						now.power_pin = 1'b1;
						ticks = '0;
						phase = ST_ON_HOLD;
					end
				end
				ST_ON_HOLD: begin
					now.led_phase_one = 1'b0;
					now.led_phase_two = 1'b1;
					if (count_hits(on_lim)) begin
						now.zero_set_pin   = 1'b0;
						now.zero_reset_pin = 1'b0;
						now.busy_flag      = 1'b0;
						now.done_flag      = 1'b1;
						ticks = '0;
						phase = ST_DONE_HOLD;
					end
				end
				ST_DONE_HOLD: begin
					now.led_phase_two   = 1'b0;
					now.led_phase_three = 1'b1;
					if (count_hits(done_lim)) begin
						now.done_flag       = 1'b0;
						now.led_phase_one   = 1'b0;
						now.led_phase_two   = 1'b0;
						now.led_phase_three = 1'b0;
						phase = ST_IDLE;
					end
				end
				default: begin
					now.led_phase_one   = 1'b0;
					now.led_phase_two   = 1'b0;
					now.led_phase_three = 1'b0;
					phase = ST_IDLE;
				end
			endcase
			owed_q.push_back(now);
		endfunction

		function void check_status(pins_t got);
			logic [8:0] w, g;
			if (owed_q.size() == 0) begin
				$display("%0t: status beat %b with no tick outstanding", $time, got);
				errors++;
				return;
			end
			w = owed_q.pop_front();
			g = got;
			for (int i = 0; i < 9; i++) begin
				if (w[8-i] !== g[8-i]) begin
					$display("%0t: %s expected %0b actual %0b", $time, field_name[i],
						w[8-i], g[8-i]);
					errors++;
				end
			end
		endfunction

		function int owed();
			return owed_q.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	cfg_reg_t                cfg_index;
	logic [TICK_WIDTH-1:0]   cfg_data;
	int                      cycle_count = 0;
	bit                      sender_steady = 1'b0;
	bit                      sink_steady = 1'b0;
	sequencer_tracker        tracker = new();

	zps_cmd_if    cmd_ch();
	zps_status_if status_ch();

	encoder_zero_power_cycle_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.status    (status_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("encoder_zero_power_cycle_sequencer test failed");
			$finish;
		end
	end

	// status sink: random stalls, every beat checked
	initial begin
		pins_t got;
		int    stall;
		int    beats;
		beats = 0;
		status_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (beats % 50 == 0)
				sink_steady = ($urandom_range(0, 3) == 0);
			stall = sink_steady ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				status_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			status_ch.ready <= 1'b1;
			@(posedge clk);
			while (!status_ch.valid)
				@(posedge clk);
			got.zero_set_pin    = status_ch.zero_set_pin;
			got.zero_reset_pin  = status_ch.zero_reset_pin;
			got.power_pin       = status_ch.power_pin;
			got.busy_flag       = status_ch.busy_flag;
			got.done_flag       = status_ch.done_flag;
			got.manual_status   = status_ch.manual_status;
			got.led_phase_one   = status_ch.led_phase_one;
			got.led_phase_two   = status_ch.led_phase_two;
			got.led_phase_three = status_ch.led_phase_three;
			tracker.check_status(got);
			beats++;
		end
	end

	// one tick beat, after a random gap
	task automatic send_tick(tick_t t);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.set_trigger   <= t.set_trigger;
		cmd_ch.reset_trigger <= t.reset_trigger;
		cmd_ch.manual_enable <= t.manual_enable;
		cmd_ch.force_set     <= t.force_set;
		cmd_ch.force_reset   <= t.force_reset;
		cmd_ch.force_power   <= t.force_power;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		tracker.accept_tick(t);
	endtask

	// hold off until every owed status beat is in
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [TICK_WIDTH-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		tracker.set_limit(idx, v);
	endtask

	// registers are only touched with nothing in flight
	task automatic set_timing(logic [TICK_WIDTH-1:0] off_v, logic [TICK_WIDTH-1:0] on_v,
			logic [TICK_WIDTH-1:0] done_v);
		wait_drained();
		repeat (3) @(posedge clk);
		write_reg(REG_OFF_TICKS, off_v);
		write_reg(REG_ON_TICKS, on_v);
		write_reg(REG_DONE_TICKS, done_v);
		cfg_we <= 1'b0;
	endtask

	// mostly triggers so sequences start as soon as idle, some manual and some noise
	function automatic tick_t random_tick();
		tick_t t;
		int    pick;
		t    = tick_t'(6'($urandom_range(0, 63)));
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			t.manual_enable = 1'b1;
		end else begin
			t.manual_enable = 1'b0;
			if (pick < 55) begin
				t.set_trigger = 1'b1;
			end else if (pick < 85) begin
				t.set_trigger   = 1'b0;
				t.reset_trigger = 1'b1;
			end else begin
				t.set_trigger   = 1'b0;
				t.reset_trigger = 1'b0;
			end
		end
		return t;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0)
				sender_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) == 0)
				wait_drained();
			send_tick(random_tick());
		end
	endtask

	// stimulus
	initial begin
		tick_t seq_check[];
		// bit order: set, reset, manual, force set, force reset, force power
		seq_check = '{
			6'b000_000, 6'b000_000, 6'b000_000, 6'b000_000,  // let any old sequence run out
			6'b110_000,                                        // both triggers, set wins
			6'b010_111,                                        // ignored in start
			6'b101_010,                                        // ignored in off wait
			6'b001_111,                                        // ignored in on hold
			6'b010_000,                                        // ignored in done hold
			6'b010_000,                                        // reset sequence
			6'b001_101,
			6'b000_000, 6'b000_000, 6'b000_000,
			6'b001_011                                         // manual again once idle
		};
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_OFF_TICKS;
		cfg_data             <= '0;
		cmd_ch.valid         <= 1'b0;
		cmd_ch.set_trigger   <= 1'b0;
		cmd_ch.reset_trigger <= 1'b0;
		cmd_ch.manual_enable <= 1'b0;
		cmd_ch.force_set     <= 1'b0;
		cmd_ch.force_reset   <= 1'b0;
		cmd_ch.force_power   <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// manual pin control, every force pattern, at reset timing
		for (int f = 0; f < 8; f++)
			send_tick(tick_t'({3'b001, f[2:0]}));
		send_tick(6'b111_101);                  // trigger with manual is dropped
		send_tick(6'b000_111);                  // forces ignored outside manual
		send_tick(6'b100_000);                  // sequence at default timing
		run_random(250);

		// zero register acts as one, then the shortest phases
		set_timing(16'd0, 16'd1, 16'd1);
		foreach (seq_check[i])
			send_tick(seq_check[i]);

		set_timing(16'd1, 16'd1, 16'd1);
		run_random(200);
		set_timing(16'd2, 16'd3, 16'd1);
		run_random(200);
		repeat (4) begin
			set_timing(TICK_WIDTH'($urandom_range(1, 6)), TICK_WIDTH'($urandom_range(1, 6)),
				TICK_WIDTH'($urandom_range(1, 6)));
			run_random(150);
		end
		// longest phases; the next write cuts them short
		set_timing(TICK_MAX, 16'd1, 16'd1);
		run_random(120);
		set_timing(16'd1, TICK_MAX, 16'd1);
		run_random(120);
		set_timing(16'd1, 16'd1, TICK_MAX);
		run_random(120);
		set_timing(TICK_MAX, TICK_MAX, TICK_MAX);
		run_random(100);
		set_timing(OFF_TICKS_RST, ON_TICKS_RST, DONE_TICKS_RST);
		run_random(60);
		set_timing(16'd1, 16'd2, 16'd1);
		run_random(200);

		wait_drained();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.owed() == 0)
			$display("encoder_zero_power_cycle_sequencer test passed");
		else
			$display("encoder_zero_power_cycle_sequencer test failed");
		$finish;
	end

endmodule : tb_encoder_zero_power_cycle_sequencer

`default_nettype wire

// ===== files.f =====
hw/rtl/zps_pkg.sv
hw/rtl/zps_cmd_if.sv
hw/rtl/zps_status_if.sv
hw/rtl/encoder_zero_power_cycle_sequencer.sv
dv/tb_encoder_zero_power_cycle_sequencer.sv
